@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker file of the hash table block.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check the consequent in the same cycle as the antecedent.
`define CHT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hash table check failed");
// Check the consequent in the cycle after the antecedent.
`define CHT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hash table check failed");
`endif

@@ hw/rtl/cht_pkg.sv @@
// Shared constants, codes and types of the chained hash table.
// No dependencies.
package cht_pkg;

  localparam int BUCKETS  = 256;
  localparam int NODES    = 1024;
  localparam int BK_W     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int NIDX_W   = $clog2(NODES);
  localparam int PTR_W    = NIDX_W + 1;
  localparam int DATA_W   = 64;
  localparam int HANDLE_W = 10;
  localparam int COUNT_W  = 11;
  localparam int ACT_W    = 2;
  localparam int ST_W     = 2;

  // Empty link marker: one past the last node
  localparam logic [PTR_W-1:0] NIL = PTR_W'(NODES);

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT  = 2'd0,
    ACT_LOOKUP  = 2'd1,
    ACT_REMOVE  = 2'd2,
    ACT_INVALID = 2'd3
  } action_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  // Datapath commands issued by the sequencer
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_POP,
    CMD_STORE,
    CMD_INS_STEP,
    CMD_LK_FIRST,
    CMD_LK_STEP,
    CMD_RM_READ,
    CMD_RM_CHECK,
    CMD_RM_FIRST,
    CMD_RM_STEP,
    CMD_RM_FREE,
    CMD_MISS,
    CMD_EMIT
  } cmd_e;

  // Datapath flags seen by the sequencer
  typedef struct packed {
    logic full;
    logic head_nil;
    logic head_is_h;
    logic next_nil;
    logic next_is_h;
    logic key_hit;
    logic rm_ok;
    logic out_busy;
  } status_t;

  function automatic logic [BK_W-1:0] bucket_of(input logic [DATA_W-1:0] k);
    logic [DATA_W-1:0] m;
    m = k & DATA_W'(BUCKETS - 1);
    return m[BK_W-1:0];
  endfunction

endpackage

@@ hw/rtl/cht_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cht_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(Depth)-1:0]         waddr_i,
  input  logic [Width-1:0]                 wdata_i,
  input  logic [$clog2(Depth)-1:0]         raddr_i,
  output logic [Width-1:0]                 rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/cht_ctrl.sv @@
// Sequencer of the hash table: one-hot state machine issuing datapath commands.
// Depends on cht_pkg.
module cht_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic [cht_pkg::ACT_W-1:0]   in_action_i,
  output logic                        in_ready_o,
  input  cht_pkg::status_t            status_i,
  output cht_pkg::cmd_e               cmd_o
);
  import cht_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE      = 14'b00000000000001,
    S_INS_POP   = 14'b00000000000010,
    S_INS_STORE = 14'b00000000000100,
    S_INS_WALK  = 14'b00000000001000,
    S_LK_HEAD   = 14'b00000000010000,
    S_LK_START  = 14'b00000000100000,
    S_LK_WALK   = 14'b00000001000000,
    S_RM_READ   = 14'b00000010000000,
    S_RM_HEAD   = 14'b00000100000000,
    S_RM_START  = 14'b00001000000000,
    S_RM_WALK   = 14'b00010000000000,
    S_RM_FREE   = 14'b00100000000000,
    S_MISS      = 14'b01000000000000,
    S_RESP      = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  // Next state and command
  always_comb begin
    state_d    = state_q;
    cmd_o      = CMD_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o = CMD_LOAD;
          case (in_action_i)
            ACT_INSERT: state_d = S_INS_POP;
            ACT_LOOKUP: state_d = S_LK_HEAD;
            ACT_REMOVE: state_d = S_RM_READ;
            default:    state_d = S_MISS;
          endcase
        end
      end
      S_INS_POP: begin
        cmd_o   = CMD_POP;
        state_d = status_i.full ? S_RESP : S_INS_STORE;
      end
      S_INS_STORE: begin
        cmd_o   = CMD_STORE;
        state_d = status_i.head_nil ? S_RESP : S_INS_WALK;
      end
      S_INS_WALK: begin
        cmd_o = CMD_INS_STEP;
        if (status_i.next_nil) state_d = S_RESP;
      end
      S_LK_HEAD: begin
        state_d = S_LK_START;
      end
      S_LK_START: begin
        cmd_o   = CMD_LK_FIRST;
        state_d = status_i.head_nil ? S_RESP : S_LK_WALK;
      end
      S_LK_WALK: begin
        cmd_o = CMD_LK_STEP;
        if (status_i.key_hit || status_i.next_nil) state_d = S_RESP;
      end
      S_RM_READ: begin
        cmd_o   = CMD_RM_READ;
        state_d = S_RM_HEAD;
      end
      S_RM_HEAD: begin
        cmd_o   = CMD_RM_CHECK;
        state_d = status_i.rm_ok ? S_RM_START : S_RESP;
      end
      S_RM_START: begin
        cmd_o   = CMD_RM_FIRST;
        state_d = (status_i.head_is_h || status_i.head_nil) ? S_RM_FREE : S_RM_WALK;
      end
      S_RM_WALK: begin
        cmd_o = CMD_RM_STEP;
        if (status_i.next_is_h || status_i.next_nil) state_d = S_RM_FREE;
      end
      S_RM_FREE: begin
        cmd_o   = CMD_RM_FREE;
        state_d = S_RESP;
      end
      S_MISS: begin
        cmd_o   = CMD_MISS;
        state_d = S_RESP;
      end
      S_RESP: begin
        if (!status_i.out_busy) begin
          cmd_o   = CMD_EMIT;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hw/rtl/cht_dp.sv @@
// Datapath of the hash table: node, bucket and free-stack memories, walk
// pointers, counters and the output register. Depends on cht_pkg, cht_ram.
module cht_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cht_pkg::cmd_e                 cmd_i,
  output cht_pkg::status_t              status_o,
  input  logic [cht_pkg::DATA_W-1:0]    in_key_i,
  input  logic [cht_pkg::DATA_W-1:0]    in_val_b_i,
  input  logic [cht_pkg::DATA_W-1:0]    in_val_c_i,
  input  logic [cht_pkg::HANDLE_W-1:0]  in_handle_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [cht_pkg::ST_W-1:0]      out_status_o,
  output logic [cht_pkg::HANDLE_W-1:0]  out_row_handle_o,
  output logic [cht_pkg::DATA_W-1:0]    out_row_key_o,
  output logic [cht_pkg::DATA_W-1:0]    out_row_b_o,
  output logic [cht_pkg::DATA_W-1:0]    out_row_c_o,
  output logic [cht_pkg::COUNT_W-1:0]   out_row_count_o
);
  import cht_pkg::*;

  // Operation registers
  logic [DATA_W-1:0] key_q, b_q, c_q;
  logic [NIDX_W-1:0] h_q, p_q, n_q;
  logic              h_ok_q;
  logic [BK_W-1:0]   bk_q;
  logic [PTR_W-1:0]  hnext_q;

  // Control state
  logic [PTR_W-1:0]   ft_q, lw_q, rows_q;
  logic [BUCKETS-1:0] hv_q;
  logic               out_valid_q;

  // Result and output registers
  status_e           res_status_q;
  logic [NIDX_W-1:0] res_handle_q;
  logic [DATA_W-1:0] res_key_q, res_b_q, res_c_q;
  logic [ST_W-1:0]     out_status_q;
  logic [HANDLE_W-1:0] out_handle_q;
  logic [DATA_W-1:0]   out_key_q, out_b_q, out_c_q;
  logic [COUNT_W-1:0]  out_count_q;

  // Memory ports
  logic [DATA_W-1:0] key_rd, b_rd, c_rd;
  logic [PTR_W-1:0]  next_rd, head_rd;
  logic              live_rd;
  logic [NIDX_W-1:0] stack_rd;
  logic [NIDX_W-1:0] node_ra, node_wa, next_wa, live_wa, stack_ra, stack_wa;
  logic [BK_W-1:0]   head_ra;
  logic              node_we, next_we, live_we, head_we, stack_we, live_wd;
  logic [PTR_W-1:0]  next_wd, head_wd;

  // Derived values
  logic [PTR_W-1:0]  head_res;
  logic [NIDX_W-1:0] n_new;
  logic              touched;

  assign head_res = hv_q[bk_q] ? head_rd : NIL;
  // Stack entries below the low-water mark were never written, so the node index is computed
  assign n_new    = (ft_q < lw_q) ? (NIDX_W'(NODES - 1) - ft_q[NIDX_W-1:0]) : stack_rd;
  assign touched  = {1'b0, NIDX_W'(NODES - 1) - h_q} >= lw_q;

  // Flags for the sequencer
  always_comb begin
    status_o.full      = (ft_q == '0);
    status_o.head_nil  = (head_res >= NIL);
    status_o.head_is_h = (head_res == {1'b0, h_q});
    status_o.next_nil  = (next_rd >= NIL);
    status_o.next_is_h = (next_rd == {1'b0, h_q});
    status_o.key_hit   = (key_rd == key_q);
    status_o.rm_ok     = h_ok_q && touched && live_rd;
    status_o.out_busy  = out_valid_q && !out_ready_i;
  end

  // Read addresses
  always_comb begin
    case (cmd_i)
      CMD_RM_READ:                          node_ra = h_q;
      CMD_STORE, CMD_LK_FIRST, CMD_RM_FIRST: node_ra = head_res[NIDX_W-1:0];
      default:                              node_ra = next_rd[NIDX_W-1:0];
    endcase
    head_ra  = (cmd_i == CMD_RM_CHECK) ? bucket_of(key_rd) : bk_q;
    stack_ra = NIDX_W'(ft_q - PTR_W'(1));
  end

  // Write ports
  always_comb begin
    node_we  = 1'b0;
    node_wa  = n_new;
    next_we  = 1'b0;
    next_wa  = p_q;
    next_wd  = NIL;
    live_we  = 1'b0;
    live_wa  = h_q;
    live_wd  = 1'b0;
    head_we  = 1'b0;
    head_wd  = hnext_q;
    stack_we = 1'b0;
    stack_wa = ft_q[NIDX_W-1:0];
    case (cmd_i)
      CMD_STORE: begin
        node_we = 1'b1;
        next_we = 1'b1;
        next_wa = n_new;
        live_we = 1'b1;
        live_wa = n_new;
        live_wd = 1'b1;
        head_we = status_o.head_nil;
        head_wd = {1'b0, n_new};
      end
      CMD_INS_STEP: begin
        next_we = status_o.next_nil;
        next_wd = {1'b0, n_q};
      end
      CMD_RM_FIRST: begin
        head_we = status_o.head_is_h;
      end
      CMD_RM_STEP: begin
        next_we = status_o.next_is_h;
        next_wd = hnext_q;
      end
      CMD_RM_FREE: begin
        next_we  = 1'b1;
        next_wa  = h_q;
        live_we  = 1'b1;
        stack_we = (ft_q < PTR_W'(NODES));
      end
      default: ;
    endcase
  end

  cht_ram #(.Width(DATA_W), .Depth(NODES)) u_key_ram (
    .clk_i, .we_i(node_we), .waddr_i(node_wa), .wdata_i(key_q),
    .raddr_i(node_ra), .rdata_o(key_rd));
  cht_ram #(.Width(DATA_W), .Depth(NODES)) u_b_ram (
    .clk_i, .we_i(node_we), .waddr_i(node_wa), .wdata_i(b_q),
    .raddr_i(node_ra), .rdata_o(b_rd));
  cht_ram #(.Width(DATA_W), .Depth(NODES)) u_c_ram (
    .clk_i, .we_i(node_we), .waddr_i(node_wa), .wdata_i(c_q),
    .raddr_i(node_ra), .rdata_o(c_rd));
  cht_ram #(.Width(PTR_W), .Depth(NODES)) u_next_ram (
    .clk_i, .we_i(next_we), .waddr_i(next_wa), .wdata_i(next_wd),
    .raddr_i(node_ra), .rdata_o(next_rd));
  cht_ram #(.Width(1), .Depth(NODES)) u_live_ram (
    .clk_i, .we_i(live_we), .waddr_i(live_wa), .wdata_i(live_wd),
    .raddr_i(node_ra), .rdata_o(live_rd));
  cht_ram #(.Width(PTR_W), .Depth(BUCKETS)) u_head_ram (
    .clk_i, .we_i(head_we), .waddr_i(bk_q), .wdata_i(head_wd),
    .raddr_i(head_ra), .rdata_o(head_rd));
  cht_ram #(.Width(NIDX_W), .Depth(NODES)) u_stack_ram (
    .clk_i, .we_i(stack_we), .waddr_i(stack_wa), .wdata_i(h_q),
    .raddr_i(stack_ra), .rdata_o(stack_rd));

  // Counters, bucket valid bits and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ft_q        <= PTR_W'(NODES);
      lw_q        <= PTR_W'(NODES);
      rows_q      <= '0;
      hv_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      case (cmd_i)
        CMD_POP: begin
          if (!status_o.full) ft_q <= ft_q - PTR_W'(1);
        end
        CMD_STORE: begin
          rows_q <= rows_q + PTR_W'(1);
          if (ft_q < lw_q) lw_q <= ft_q;
          if (status_o.head_nil) hv_q[bk_q] <= 1'b1;
        end
        CMD_RM_FREE: begin
          if (ft_q < PTR_W'(NODES)) ft_q <= ft_q + PTR_W'(1);
          if (rows_q != '0) rows_q <= rows_q - PTR_W'(1);
        end
        default: ;
      endcase
      if (cmd_i == CMD_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Operands, walk pointers, result and output registers
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_LOAD: begin
        key_q  <= in_key_i;
        b_q    <= in_val_b_i;
        c_q    <= in_val_c_i;
        h_q    <= NIDX_W'(in_handle_i);
        h_ok_q <= (32'(in_handle_i) < NODES);
        bk_q   <= bucket_of(in_key_i);
      end
      CMD_POP: begin
        if (status_o.full) begin
          res_status_q <= ST_FULL;
          res_handle_q <= '0;
          res_key_q    <= '0;
          res_b_q      <= '0;
          res_c_q      <= '0;
        end
      end
      CMD_STORE: begin
        n_q          <= n_new;
        res_status_q <= ST_OK;
        res_handle_q <= n_new;
        res_key_q    <= key_q;
        res_b_q      <= b_q;
        res_c_q      <= c_q;
        if (!status_o.head_nil) p_q <= head_res[NIDX_W-1:0];
      end
      CMD_INS_STEP: begin
        if (!status_o.next_nil) p_q <= next_rd[NIDX_W-1:0];
      end
      CMD_LK_FIRST: begin
        if (status_o.head_nil) begin
          res_status_q <= ST_NOT_FOUND;
          res_handle_q <= '0;
          res_key_q    <= '0;
          res_b_q      <= '0;
          res_c_q      <= '0;
        end else begin
          p_q <= head_res[NIDX_W-1:0];
        end
      end
      CMD_LK_STEP: begin
        if (status_o.key_hit) begin
          res_status_q <= ST_OK;
          res_handle_q <= p_q;
          res_key_q    <= key_rd;
          res_b_q      <= b_rd;
          res_c_q      <= c_rd;
        end else if (status_o.next_nil) begin
          res_status_q <= ST_NOT_FOUND;
          res_handle_q <= '0;
          res_key_q    <= '0;
          res_b_q      <= '0;
          res_c_q      <= '0;
        end else begin
          p_q <= next_rd[NIDX_W-1:0];
        end
      end
      CMD_RM_CHECK: begin
        if (status_o.rm_ok) begin
          res_status_q <= ST_OK;
          res_handle_q <= h_q;
          res_key_q    <= key_rd;
          res_b_q      <= b_rd;
          res_c_q      <= c_rd;
          hnext_q      <= next_rd;
          bk_q         <= bucket_of(key_rd);
        end else begin
          res_status_q <= ST_NOT_FOUND;
          res_handle_q <= '0;
          res_key_q    <= '0;
          res_b_q      <= '0;
          res_c_q      <= '0;
        end
      end
      CMD_RM_FIRST: begin
        if (!status_o.head_is_h && !status_o.head_nil) p_q <= head_res[NIDX_W-1:0];
      end
      CMD_RM_STEP: begin
        if (!status_o.next_is_h && !status_o.next_nil) p_q <= next_rd[NIDX_W-1:0];
      end
      CMD_MISS: begin
        res_status_q <= ST_NOT_FOUND;
        res_handle_q <= '0;
        res_key_q    <= '0;
        res_b_q      <= '0;
        res_c_q      <= '0;
      end
      CMD_EMIT: begin
        out_status_q <= res_status_q;
        out_handle_q <= HANDLE_W'(res_handle_q);
        out_key_q    <= res_key_q;
        out_b_q      <= res_b_q;
        out_c_q      <= res_c_q;
        out_count_q  <= COUNT_W'(rows_q);
      end
      default: ;
    endcase
  end

  assign out_valid_o      = out_valid_q;
  assign out_status_o     = out_status_q;
  assign out_row_handle_o = out_handle_q;
  assign out_row_key_o    = out_key_q;
  assign out_row_b_o      = out_b_q;
  assign out_row_c_o      = out_c_q;
  assign out_row_count_o  = out_count_q;

endmodule

@@ hw/rtl/chained_hash_table_top.sv @@
// Chained hash table with a fixed node pool: one operation at a time. Insert
// runs pop, store and a walk step per node already in the target bucket chain,
// lookup a head read, a start and a walk step per node visited, remove a row
// read, a check, a start, a walk step per node ahead of the removed row in its
// chain and a free; each is taken in idle and holds in its response step while
// the previous result is not taken. The chain walk follows one link per cycle,
// set by the registered read of the link memory. No clearing pass after reset
// is needed. Depends on cht_pkg, cht_ctrl, cht_dp.
module chained_hash_table_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [cht_pkg::ACT_W-1:0]     in_action_i,
  input  logic [cht_pkg::DATA_W-1:0]    in_key_i,
  input  logic [cht_pkg::DATA_W-1:0]    in_val_b_i,
  input  logic [cht_pkg::DATA_W-1:0]    in_val_c_i,
  input  logic [cht_pkg::HANDLE_W-1:0]  in_handle_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [cht_pkg::ST_W-1:0]      out_status_o,
  output logic [cht_pkg::HANDLE_W-1:0]  out_row_handle_o,
  output logic [cht_pkg::DATA_W-1:0]    out_row_key_o,
  output logic [cht_pkg::DATA_W-1:0]    out_row_b_o,
  output logic [cht_pkg::DATA_W-1:0]    out_row_c_o,
  output logic [cht_pkg::COUNT_W-1:0]   out_row_count_o
);
  import cht_pkg::*;

  cmd_e    cmd;
  status_t status;

  cht_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_action_i,
    .in_ready_o,
    .status_i (status),
    .cmd_o    (cmd)
  );

  cht_dp u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i    (cmd),
    .status_o (status),
    .in_key_i,
    .in_val_b_i,
    .in_val_c_i,
    .in_handle_i,
    .out_valid_o,
    .out_ready_i,
    .out_status_o,
    .out_row_handle_o,
    .out_row_key_o,
    .out_row_b_o,
    .out_row_c_o,
    .out_row_count_o
  );

endmodule

@@ hw/rtl/cht_checker.sv @@
// Port-level checks of the hash table, bound to the top level.
// Depends on cht_pkg and assert_macros.svh.
`include "assert_macros.svh"
module cht_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic [cht_pkg::ACT_W-1:0]     in_action_i,
  input logic [cht_pkg::DATA_W-1:0]    in_key_i,
  input logic [cht_pkg::DATA_W-1:0]    in_val_b_i,
  input logic [cht_pkg::DATA_W-1:0]    in_val_c_i,
  input logic [cht_pkg::HANDLE_W-1:0]  in_handle_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [cht_pkg::ST_W-1:0]      out_status_o,
  input logic [cht_pkg::HANDLE_W-1:0]  out_row_handle_o,
  input logic [cht_pkg::DATA_W-1:0]    out_row_key_o,
  input logic [cht_pkg::DATA_W-1:0]    out_row_b_o,
  input logic [cht_pkg::DATA_W-1:0]    out_row_c_o,
  input logic [cht_pkg::COUNT_W-1:0]   out_row_count_o
);
  import cht_pkg::*;

  // Hold a stalled result
  `CHT_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_row_key_o) && $stable(out_row_count_o))
  // Take one operation at a time
  `CHT_ASSERT_NEXT(a_one_op, in_valid_i && in_ready_o, !in_ready_o)
  // Row count stays within the pool
  `CHT_ASSERT_NOW(a_count_range, out_valid_o, out_row_count_o <= COUNT_W'(NODES))
  // Pool full only when every node holds a row
  `CHT_ASSERT_NOW(a_full_count, out_valid_o && (out_status_o == ST_FULL), out_row_count_o == COUNT_W'(NODES))
  // Failed operations report a zero handle, key and c field
  `CHT_ASSERT_NOW(a_fail_zero, out_valid_o && (out_status_o != ST_OK), (out_row_handle_o == '0) && (out_row_key_o == '0) && (out_row_c_o == '0))

endmodule

bind chained_hash_table_top cht_checker u_cht_checker (.*);
